// ===== src/wvbd_pkg.sv =====
// Package for the window vote button debouncer.
// Holds the command codes, configuration indexes, register widths and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wvbd_pkg;

  // Widest button count that the result fields carry.
  localparam int MaxButtons = 8;

  // Default sizes of the block.
  localparam int DefNumButtons = 8;
  localparam int DefWindowLen  = 8;

  // Field widths.
  localparam int CmdW    = 2;
  localparam int IndexW  = 3;
  localparam int TickW   = 32;
  localparam int ThrW    = 4;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 4;

  // Commands carried by an input item.
  typedef enum logic [CmdW-1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_CLEAR_ONE = 2'd1,
    CMD_CLEAR_ALL = 2'd2
  } cmd_e;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ON_THRESHOLD   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OFF_THRESHOLD  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INVERT_LEVELS  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_EVENTS = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [ThrW-1:0] RstOnThreshold   = 4'd5;
  localparam logic [ThrW-1:0] RstOffThreshold  = 4'd5;
  localparam logic            RstInvertLevels  = 1'b1;
  localparam logic            RstReleaseEvents = 1'b0;

  // Configuration as seen by the update logic.
  typedef struct packed {
    logic [ThrW-1:0] on_threshold;
    logic [ThrW-1:0] off_threshold;
    logic            invert_levels;
    logic            release_events;
  } cfg_t;

endpackage : wvbd_pkg

`default_nettype wire

// ===== src/wvbd_if.sv =====
// Valid/ready channel interfaces for the debouncer input and result items.
// Depends on wvbd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface wvbd_in_if;
  logic                          valid;
  logic                          ready;
  logic [wvbd_pkg::CmdW-1:0]     cmd;
  logic [wvbd_pkg::MaxButtons-1:0] raw_levels;
  logic [wvbd_pkg::IndexW-1:0]   clear_index;
  logic [wvbd_pkg::TickW-1:0]    tick_now;

  modport source (output valid, cmd, raw_levels, clear_index, tick_now, input ready);
  modport sink   (input valid, cmd, raw_levels, clear_index, tick_now, output ready);
endinterface : wvbd_in_if

interface wvbd_out_if;
  logic                            valid;
  logic                            ready;
  logic [wvbd_pkg::MaxButtons-1:0] event_bits;
  logic [wvbd_pkg::MaxButtons-1:0] pressed_bits;
  logic [wvbd_pkg::TickW-1:0]      last_event_time;

  modport source (output valid, event_bits, pressed_bits, last_event_time, input ready);
  modport sink   (input valid, event_bits, pressed_bits, last_event_time, output ready);
endinterface : wvbd_out_if

`default_nettype wire

// ===== src/wvbd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wvbd_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                     wdata_i,
  input  wire logic                                 re_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : wvbd_ram

`default_nettype wire

// ===== src/wvbd_update.sv =====
// Second stage of the debouncer: window counts, press and release decisions,
// event flags and time, which also form the result item. Depends on wvbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wvbd_update #(
  parameter int NUM_BUTTONS = wvbd_pkg::DefNumButtons,
  parameter int WINDOW_LEN  = wvbd_pkg::DefWindowLen
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire wvbd_pkg::cfg_t                   cfg_i,
  input  wire logic                             s1_valid_i,
  input  wire logic [wvbd_pkg::CmdW-1:0]        s1_cmd_i,
  input  wire logic [NUM_BUTTONS-1:0]           s1_levels_i,
  input  wire logic [NUM_BUTTONS-1:0]           s1_old_levels_i,
  input  wire logic [wvbd_pkg::IndexW-1:0]      s1_clear_index_i,
  input  wire logic [wvbd_pkg::TickW-1:0]       s1_tick_i,
  output logic                                  s1_fire_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [wvbd_pkg::MaxButtons-1:0]       event_bits_o,
  output logic [wvbd_pkg::MaxButtons-1:0]       pressed_bits_o,
  output logic [wvbd_pkg::TickW-1:0]            last_event_time_o
);

  localparam int CntW = $clog2(WINDOW_LEN + 1);
  localparam int CmpW = (CntW > wvbd_pkg::ThrW ? CntW : wvbd_pkg::ThrW) + 1;
  localparam logic [CmpW-1:0] WinC = CmpW'(WINDOW_LEN);

  logic [CntW-1:0]              cnt_q [NUM_BUTTONS];
  logic [CntW-1:0]              cnt_d [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0]       pressed_q, pressed_d;
  logic [NUM_BUTTONS-1:0]       events_q, events_d;
  logic [wvbd_pkg::TickW-1:0]   time_q, time_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_space;
  logic                         raised;
  logic [CmpW-1:0]              on_c;
  logic [CmpW-1:0]              off_c;
  logic [CmpW-1:0]              cnt_c;

  // The result item is the state itself, so the state only moves when the
  // previous result has gone.
  assign out_space = !out_valid_q || out_ready_i;
  assign s1_fire_o = s1_valid_i && out_space;

  assign on_c  = CmpW'(cfg_i.on_threshold);
  assign off_c = CmpW'(cfg_i.off_threshold);

  // Count update and press/release decisions for every button.
  always_comb begin
    pressed_d = pressed_q;
    events_d  = events_q;
    time_d    = time_q;
    raised    = 1'b0;
    cnt_c     = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      cnt_d[b] = cnt_q[b];
    end
    if (s1_fire_o) begin
      case (s1_cmd_i)
        wvbd_pkg::CMD_SAMPLE: begin
          for (int b = 0; b < NUM_BUTTONS; b++) begin
            cnt_d[b] = cnt_q[b] + CntW'(s1_levels_i[b]) - CntW'(s1_old_levels_i[b]);
            cnt_c    = CmpW'(cnt_d[b]);
            if (!pressed_q[b]) begin
              if (cnt_c >= on_c) begin
                pressed_d[b] = 1'b1;
                if (!cfg_i.release_events) begin
                  events_d[b] = 1'b1;
                  raised      = 1'b1;
                end
              end
            end else if ((off_c <= WinC) && (cnt_c <= (WinC - off_c))) begin
              pressed_d[b] = 1'b0;
              if (cfg_i.release_events) begin
                events_d[b] = 1'b1;
                raised      = 1'b1;
              end
            end
          end
          if (raised) begin
            time_d = s1_tick_i;
          end
        end
        wvbd_pkg::CMD_CLEAR_ONE: begin
          for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (s1_clear_index_i == wvbd_pkg::IndexW'(b)) begin
              events_d[b] = 1'b0;
            end
          end
        end
        wvbd_pkg::CMD_CLEAR_ALL: begin
          events_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result valid: set when an item finishes, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        cnt_q[b] <= '0;
      end
      pressed_q   <= '0;
      events_q    <= '0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        cnt_q[b] <= cnt_d[b];
      end
      pressed_q   <= pressed_d;
      events_q    <= events_d;
      time_q      <= time_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_bits_o      = wvbd_pkg::MaxButtons'(events_q);
  assign pressed_bits_o    = wvbd_pkg::MaxButtons'(pressed_q);
  assign last_event_time_o = time_q;

endmodule : wvbd_update

`default_nettype wire

// ===== src/window_vote_button_debouncer.sv =====
// Top level of the window vote button debouncer: configuration registers,
// ring write pointer, sample history RAM and the update stage.
// Depends on wvbd_pkg, wvbd_if, wvbd_ram and wvbd_update.
//
//   Channel   Direction  Handshake          Carries
//   in_ch     sink       valid/ready        cmd, raw_levels, clear_index, tick_now
//   out_ch    source     valid/ready        event_bits, pressed_bits, last_event_time
//   cfg       input      cfg_we_i           cfg_index_i, cfg_wdata_i
//
// One item per cycle while the output does not stall. The overwritten ring slot is read
// from the history RAM at the edge that accepts the item; counts and flags are then
// updated in the update stage and registered as the result item. A write to
// the slot being read is forwarded. The ring needs no clearing pass: until the
// write pointer first wraps, the overwritten slot reads as zero. Output stalls
// hold the update stage, and input is taken whenever that stage is empty or moves on.
`timescale 1ns / 1ps
`default_nettype none

module window_vote_button_debouncer #(
  parameter int NUM_BUTTONS = wvbd_pkg::DefNumButtons,
  parameter int WINDOW_LEN  = wvbd_pkg::DefWindowLen
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [wvbd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [wvbd_pkg::CfgDatW-1:0]  cfg_wdata_i,
  wvbd_in_if.sink                            in_ch,
  wvbd_out_if.source                         out_ch
);

  localparam int SlotW = WINDOW_LEN > 1 ? $clog2(WINDOW_LEN) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(WINDOW_LEN - 1);

  wvbd_pkg::cfg_t              cfg_q, cfg_d;
  logic [SlotW-1:0]            slot_q, slot_d;
  logic                        wrapped_q, wrapped_d;
  logic                        in_acc;
  logic                        tick_acc;
  logic [NUM_BUTTONS-1:0]      levels;

  // Update stage payload.
  logic                        s1_valid_q, s1_valid_d;
  logic [wvbd_pkg::CmdW-1:0]   s1_cmd_q;
  logic [NUM_BUTTONS-1:0]      s1_levels_q;
  logic [wvbd_pkg::IndexW-1:0] s1_clear_index_q;
  logic [wvbd_pkg::TickW-1:0]  s1_tick_q;
  logic [SlotW-1:0]            s1_slot_q;
  logic                        s1_old_valid_q;
  logic                        s1_fwd_q, s1_fwd_d;
  logic [NUM_BUTTONS-1:0]      s1_fwd_data_q;
  logic                        s1_fire;
  logic                        s1_is_tick;
  logic                        ram_we;
  logic [NUM_BUTTONS-1:0]      ram_rdata;
  logic [NUM_BUTTONS-1:0]      old_levels;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        wvbd_pkg::CFG_ON_THRESHOLD:   cfg_d.on_threshold   = cfg_wdata_i;
        wvbd_pkg::CFG_OFF_THRESHOLD:  cfg_d.off_threshold  = cfg_wdata_i;
        wvbd_pkg::CFG_INVERT_LEVELS:  cfg_d.invert_levels  = cfg_wdata_i[0];
        wvbd_pkg::CFG_RELEASE_EVENTS: cfg_d.release_events = cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Input handshake and sample conditioning.
  assign in_ch.ready = !s1_valid_q || s1_fire;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign tick_acc    = in_acc && (in_ch.cmd == wvbd_pkg::CMD_SAMPLE);
  assign levels      = in_ch.raw_levels[NUM_BUTTONS-1:0] ^ {NUM_BUTTONS{cfg_q.invert_levels}};

  // Ring write pointer; the wrapped flag marks every slot as written.
  always_comb begin
    slot_d    = slot_q;
    wrapped_d = wrapped_q;
    if (tick_acc) begin
      if (slot_q == LastSlot) begin
        slot_d    = '0;
        wrapped_d = 1'b1;
      end else begin
        slot_d = slot_q + SlotW'(1);
      end
    end
  end

  // Update stage occupancy and same-slot forwarding.
  assign s1_is_tick = (s1_cmd_q == wvbd_pkg::CMD_SAMPLE);
  assign ram_we     = s1_fire && s1_is_tick;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    s1_fwd_d = tick_acc && ram_we && (s1_slot_q == slot_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_threshold   <= wvbd_pkg::RstOnThreshold;
      cfg_q.off_threshold  <= wvbd_pkg::RstOffThreshold;
      cfg_q.invert_levels  <= wvbd_pkg::RstInvertLevels;
      cfg_q.release_events <= wvbd_pkg::RstReleaseEvents;
      slot_q               <= '0;
      wrapped_q            <= 1'b0;
      s1_valid_q           <= 1'b0;
    end else begin
      cfg_q      <= cfg_d;
      slot_q     <= slot_d;
      wrapped_q  <= wrapped_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // Payload of the update stage.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q         <= in_ch.cmd;
      s1_levels_q      <= levels;
      s1_clear_index_q <= in_ch.clear_index;
      s1_tick_q        <= in_ch.tick_now;
      s1_slot_q        <= slot_q;
      s1_old_valid_q   <= wrapped_q;
      s1_fwd_q         <= s1_fwd_d;
      s1_fwd_data_q    <= s1_levels_q;
    end
  end

  // Sample history ring.
  wvbd_ram #(
    .Width (NUM_BUTTONS),
    .Depth (WINDOW_LEN)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_slot_q),
    .wdata_i (s1_levels_q),
    .re_i    (tick_acc),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  // Sample leaving the window: forwarded, read back, or zero before wrapping.
  always_comb begin
    if (s1_fwd_q) begin
      old_levels = s1_fwd_data_q;
    end else if (s1_old_valid_q) begin
      old_levels = ram_rdata;
    end else begin
      old_levels = '0;
    end
  end

  wvbd_update #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .WINDOW_LEN  (WINDOW_LEN)
  ) u_update (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .s1_valid_i        (s1_valid_q),
    .s1_cmd_i          (s1_cmd_q),
    .s1_levels_i       (s1_levels_q),
    .s1_old_levels_i   (old_levels),
    .s1_clear_index_i  (s1_clear_index_q),
    .s1_tick_i         (s1_tick_q),
    .s1_fire_o         (s1_fire),
    .out_valid_o       (out_ch.valid),
    .out_ready_i       (out_ch.ready),
    .event_bits_o      (out_ch.event_bits),
    .pressed_bits_o    (out_ch.pressed_bits),
    .last_event_time_o (out_ch.last_event_time)
  );

endmodule : window_vote_button_debouncer

`default_nettype wire

// ===== verif/window_vote_button_debouncer_tb.sv =====
// Self-checking testbench for the window vote button debouncer.
// Covers press and release voting, event latching and clearing, and threshold extremes.
// Depends on wvbd_pkg, wvbd_if and the window_vote_button_debouncer RTL.
`timescale 1ns / 1ps

module window_vote_button_debouncer_tb;
  import wvbd_pkg::*;

  localparam int NumButtons = DefNumButtons;
  localparam int WindowLen  = DefWindowLen;
  localparam int StallLimit = 4000;
  localparam int PrintLimit = 50;
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  // One result item as the block reports it.
  typedef struct packed {
    logic [MaxButtons-1:0] event_bits;
    logic [MaxButtons-1:0] pressed_bits;
    logic [TickW-1:0]      last_event_time;
  } button_status_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDatW-1:0]  cfg_wdata_i;

  wvbd_in_if  in_ch();
  wvbd_out_if out_ch();

  window_vote_button_debouncer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Predicted state of the debouncer, starting from its reset values.
  logic [MaxButtons-1:0] win_ring [WindowLen];
  int                    win_slot = 0;
  logic [MaxButtons-1:0] pressed_state = '0;
  logic [MaxButtons-1:0] event_latch = '0;
  logic [TickW-1:0]      event_stamp = '0;
  int                    cfg_on_thr = int'(RstOnThreshold);
  int                    cfg_off_thr = int'(RstOffThreshold);
  logic                  cfg_invert_levels = RstInvertLevels;
  logic                  cfg_release_events = RstReleaseEvents;

  button_status_t awaited_status [$];

  // Idling controls and bookkeeping.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holdoff_request = 0;
  int unsigned holdoff_left = 0;
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          items_accepted = 0;
  int          results_checked = 0;
  int          ticks_taken = 0;
  int          clears_taken = 0;
  int          presses_seen = 0;
  int          releases_seen = 0;

  // Stimulus helpers for the random part.
  logic [MaxButtons-1:0] button_level = '0;
  logic [TickW-1:0]      clock_ms = '0;

  initial begin
    for (int k = 0; k < WindowLen; k++) win_ring[k] = '0;
  end

  // Prints one line per mismatch, up to a limit, and counts every one.
  task automatic report_mismatch(input string what, input logic [TickW-1:0] got,
                                 input logic [TickW-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PrintLimit)
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
  endtask

  // Applies one accepted item to the predicted state and queues the status it leads to.
  task automatic debounce_step(input logic [CmdW-1:0] cmd, input logic [MaxButtons-1:0] raw,
                               input logic [IndexW-1:0] idx, input logic [TickW-1:0] now);
    logic [MaxButtons-1:0] level;
    int active;
    int b;
    int k;
    case (cmd)
      CMD_SAMPLE: begin
        level = cfg_invert_levels ? ~raw : raw;
        win_ring[win_slot] = level;
        win_slot = (win_slot == WindowLen - 1) ? 0 : win_slot + 1;
        for (b = 0; b < NumButtons; b++) begin
          active = 0;
          for (k = 0; k < WindowLen; k++) active += int'(win_ring[k][b]);
          // A released button is only tested for a press, a pressed one only for a release.
          if (!pressed_state[b]) begin
            if (active >= cfg_on_thr) begin
              pressed_state[b] = 1'b1;
              presses_seen++;
              if (!cfg_release_events) begin
                event_latch[b] = 1'b1;
                event_stamp = now;
              end
            end
          end else if (cfg_off_thr <= WindowLen && active <= WindowLen - cfg_off_thr) begin
            pressed_state[b] = 1'b0;
            releases_seen++;
            if (cfg_release_events) begin
              event_latch[b] = 1'b1;
              event_stamp = now;
            end
          end
        end
        ticks_taken++;
      end
      CMD_CLEAR_ONE: begin
        event_latch[idx] = 1'b0;
        clears_taken++;
      end
      CMD_CLEAR_ALL: begin
        event_latch = '0;
        clears_taken++;
      end
      default: ; // The unused command leaves everything as it is.
    endcase
    awaited_status.push_back('{event_latch, pressed_state, event_stamp});
  endtask

  // Watches both channels: checks each result item, predicts each input item and
  // ends the run when nothing moves for too long while work is outstanding.
  always @(posedge clk_i) begin : channel_monitor
    button_status_t want;
    logic moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        results_checked++;
        if (awaited_status.size() == 0) begin
          report_mismatch("result with none expected", out_ch.last_event_time, '0);
        end else begin
          want = awaited_status.pop_front();
          if (out_ch.event_bits !== want.event_bits)
            report_mismatch("event_bits", TickW'(out_ch.event_bits),
                            TickW'(want.event_bits));
          if (out_ch.pressed_bits !== want.pressed_bits)
            report_mismatch("pressed_bits", TickW'(out_ch.pressed_bits),
                            TickW'(want.pressed_bits));
          if (out_ch.last_event_time !== want.last_event_time)
            report_mismatch("last_event_time", out_ch.last_event_time, want.last_event_time);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        items_accepted++;
        debounce_step(in_ch.cmd, in_ch.raw_levels, in_ch.clear_index, in_ch.tick_now);
      end
      if (moved || !(in_ch.valid || awaited_status.size() != 0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("TIMEOUT: no item moved for %0d cycles at %0t", StallLimit, $time);
          $display("window_vote_button_debouncer verification failed");
          $finish;
        end
      end
    end
  end

  // Result receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk_i) begin
    if (holdoff_request != 0) begin
      holdoff_left = holdoff_request;
      holdoff_request = 0;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one item, after a random gap, and returns at the edge that accepts it.
  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [MaxButtons-1:0] raw,
                           input logic [IndexW-1:0] idx, input logic [TickW-1:0] now);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.raw_levels  <= raw;
    in_ch.clear_index <= idx;
    in_ch.tick_now    <= now;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Stops offering items and waits until every predicted result has arrived.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes one configuration register and mirrors it in the prediction.
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_ON_THRESHOLD:   cfg_on_thr = int'(val);
      CFG_OFF_THRESHOLD:  cfg_off_thr = int'(val);
      CFG_INVERT_LEVELS:  cfg_invert_levels = val[0];
      CFG_RELEASE_EVENTS: cfg_release_events = val[0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Lets the block go idle, then writes all four registers.
  task automatic apply_settings(input logic [CfgDatW-1:0] on_thr,
                                input logic [CfgDatW-1:0] off_thr,
                                input logic invert, input logic release_ev);
    drain_results();
    write_register(CFG_ON_THRESHOLD, on_thr);
    write_register(CFG_OFF_THRESHOLD, off_thr);
    write_register(CFG_INVERT_LEVELS, {3'b000, invert});
    write_register(CFG_RELEASE_EVENTS, {3'b000, release_ev});
  endtask

  // Mostly bouncing but well-formed button traffic, with some noise and clears.
  task automatic send_random_item();
    int unsigned pick;
    logic [MaxButtons-1:0] bounce;
    logic [MaxButtons-1:0] pins;
    pick = $urandom_range(99);
    clock_ms = clock_ms + $urandom_range(1, 40);
    if (pick < 70) begin
      button_level = button_level ^ MaxButtons'($urandom & $urandom & $urandom & $urandom);
      bounce = MaxButtons'($urandom & $urandom & $urandom);
      pins = cfg_invert_levels ? ~(button_level ^ bounce) : (button_level ^ bounce);
      send_item(CMD_SAMPLE, pins, IndexW'($urandom), clock_ms);
    end else if (pick < 78) begin
      send_item(CMD_SAMPLE, MaxButtons'($urandom), IndexW'($urandom), clock_ms);
    end else if (pick < 88) begin
      send_item(CMD_CLEAR_ONE, MaxButtons'($urandom),
                IndexW'($urandom_range(NumButtons - 1)), clock_ms);
    end else if (pick < 94) begin
      send_item(CMD_CLEAR_ALL, MaxButtons'($urandom), IndexW'($urandom), clock_ms);
    end else begin
      send_item(CMD_UNUSED, MaxButtons'($urandom), IndexW'($urandom), clock_ms);
    end
  endtask

  // Reset settings: a press after five active samples, a release after five idle
  // ones, event clearing and the unused command.
  task automatic test_default_press_release();
    int n;
    send_item(CMD_UNUSED, 8'h00, 3'd5, 32'h1234_5678);
    for (n = 0; n < 4; n++) send_item(CMD_SAMPLE, 8'h00, 3'd0, TickW'(n));
    send_item(CMD_SAMPLE, 8'h00, 3'd7, 32'hFFFF_FFFF);
    send_item(CMD_CLEAR_ONE, 8'hFF, 3'd0, 32'h0);
    send_item(CMD_CLEAR_ONE, 8'h00, 3'd7, 32'hFFFF_FFFF);
    send_item(CMD_CLEAR_ALL, 8'h5A, 3'd3, 32'h0);
    for (n = 0; n < 5; n++) send_item(CMD_SAMPLE, 8'hFF, 3'd2, 32'h8000_0000 + TickW'(n));
    send_item(CMD_SAMPLE, 8'h5A, 3'd1, 32'h7FFF_FFFF);
  endtask

  // Threshold extremes: zero, full window and values beyond the window.
  task automatic test_threshold_extremes();
    int n;
    // A zero press threshold presses at once; a zero release threshold releases at once.
    apply_settings(4'd0, 4'd0, 1'b0, 1'b1);
    for (n = 0; n < 3; n++) send_item(CMD_SAMPLE, 8'h00, 3'd0, 32'hA000_0000 + TickW'(n));
    // Release threshold above the window holds every pressed button.
    apply_settings(4'd9, 4'd9, 1'b0, 1'b1);
    send_item(CMD_SAMPLE, 8'hFF, 3'd0, 32'h0000_00FF);
    send_item(CMD_SAMPLE, 8'h00, 3'd0, 32'h0000_0100);
    send_item(CMD_CLEAR_ALL, 8'h00, 3'd0, 32'h0);
    // Full-window thresholds on both sides.
    apply_settings(4'd8, 4'd8, 1'b1, 1'b0);
    for (n = 0; n < 3; n++) send_item(CMD_SAMPLE, 8'hFF, 3'd6, 32'h5555_5555);
    // Press threshold far above the window never presses.
    apply_settings(4'd15, 4'd15, 1'b1, 1'b0);
    send_item(CMD_SAMPLE, 8'h00, 3'd0, 32'hAAAA_AAAA);
    send_item(CMD_SAMPLE, 8'h00, 3'd0, 32'h0F0F_0F0F);
  endtask

  // Long output hold-off so the block fills and stalls its input, then a pause
  // until every result is back before more traffic.
  task automatic test_backpressure();
    int n;
    apply_settings(4'd3, 4'd3, 1'b1, 1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    clock_ms = $urandom;
    holdoff_request = 150;
    for (n = 0; n < 60; n++) send_random_item();
    drain_results();
    for (n = 0; n < 20; n++) send_random_item();
  endtask

  // Random traffic under each idling pattern, each with its own settings.
  task automatic test_idling_phases();
    int phase;
    int n;
    logic [CfgDatW-1:0] on_v;
    logic [CfgDatW-1:0] off_v;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: apply_settings(4'd8, 4'd8, 1'b0, 1'b0);
        1: apply_settings(4'd1, 4'd1, 1'b1, 1'b1);
        default: begin
          on_v  = ($urandom_range(7) == 0) ? 4'd15 : 4'($urandom_range(8));
          off_v = ($urandom_range(7) == 0) ? 4'd15 : 4'($urandom_range(8));
          apply_settings(on_v, off_v, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      endcase
      send_idle_pct  = (phase == 1) ? 75 : (phase == 3) ? 37 : 0;
      recv_stall_pct = (phase == 2) ? 75 : (phase == 3) ? 37 : 0;
      clock_ms = $urandom;
      button_level = MaxButtons'($urandom);
      for (n = 0; n < 210; n++) send_random_item();
    end
  endtask

  // Test sequence.
  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = '0;
    cfg_wdata_i       = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = '0;
    in_ch.raw_levels  = '0;
    in_ch.clear_index = '0;
    in_ch.tick_now    = '0;
    out_ch.ready      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_press_release();
    test_threshold_extremes();
    test_backpressure();
    test_idling_phases();
    drain_results();

    if (awaited_status.size() != 0)
      report_mismatch("results never delivered", TickW'(awaited_status.size()), '0);

    $display("Run covered %0d items: %0d sample ticks, %0d event clears, %0d presses, %0d releases.",
             items_accepted, ticks_taken, clears_taken, presses_seen, releases_seen);
    $display("%0d results checked over threshold extremes, a long hold-off and four idling mixes.",
             results_checked);
    if (mismatch_count == 0) begin
      $display("window_vote_button_debouncer verification clean");
    end else begin
      $display("window_vote_button_debouncer verification failed");
    end
    $finish;
  end

endmodule : window_vote_button_debouncer_tb
